FILE: rtl/lsse_pkg.sv
// shared types and constants for the led string spi frame encoder
package lsse_pkg;

  localparam int unsigned ColorW         = 8;
  localparam int unsigned LineBitsPerBit = 3;
  localparam int unsigned LaneW          = ColorW * LineBitsPerBit;
  localparam int unsigned NumLanes       = 3;
  localparam int unsigned WordW          = LaneW * NumLanes;
  localparam int unsigned BytesPerPixel  = WordW / 8;
  localparam int unsigned GapBytesDefault = 40;

  localparam logic [LineBitsPerBit-1:0] LineOne  = 3'b110;
  localparam logic [LineBitsPerBit-1:0] LineZero = 3'b100;

  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       reset_fill;
    logic       run_last;
  } spi_out_t;

  // staged pixel handed from the lanes to the serializer
  typedef struct packed {
    logic             valid;
    logic             frame_end;
    logic [WordW-1:0] bits;
  } stage_t;

endpackage

FILE: rtl/lsse_lane.sv
// one color lane: expands a color byte into 24 line bits and registers them
module lsse_lane (
  input  logic                      clk,
  input  logic                      load,
  input  logic [lsse_pkg::ColorW-1:0] color,
  output logic [lsse_pkg::LaneW-1:0]  code
);
  import lsse_pkg::*;

  logic [LaneW-1:0] code_next;

  always_comb begin
    for (int k = 0; k < ColorW; k++) begin
      code_next[LaneW-1-LineBitsPerBit*k -: LineBitsPerBit] =
        color[ColorW-1-k] ? LineOne : LineZero;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code <= code_next;
    end
  end

endmodule

FILE: rtl/lsse_merge.sv
// serializer merging lane words into bytes; frame ends get the reset gap
module lsse_merge #(
  parameter int unsigned RESET_GAP_BYTES = lsse_pkg::GapBytesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  lsse_pkg::stage_t   stage,
  output logic               stage_take,
  output logic               spi_valid,
  input  logic               spi_ready,
  output lsse_pkg::spi_out_t spi
);
  import lsse_pkg::*;

  localparam int unsigned RunMax = BytesPerPixel + RESET_GAP_BYTES;
  localparam int unsigned PosW   = $clog2(RunMax);
  localparam logic [PosW-1:0] PixLast = PosW'(BytesPerPixel - 1);
  localparam logic [PosW-1:0] GapLast = PosW'(RunMax - 1);

  logic             busy;
  logic             frame_end;
  logic [WordW-1:0] word;
  logic [PosW-1:0]  pos;

  logic             adv;
  logic             emit;
  logic             in_gap;
  logic             last_byte;
  spi_out_t         spi_next;

  assign adv       = !spi_valid || spi_ready;
  assign emit      = busy && adv;
  assign in_gap    = (pos > PixLast);
  assign last_byte = frame_end ? (pos == GapLast) : (pos == PixLast);
  assign stage_take = stage.valid && (!busy || (emit && last_byte));

  always_comb begin
    spi_next.spi_byte   = in_gap ? 8'h00 : word[WordW-1 -: 8];
    spi_next.reset_fill = in_gap;
    spi_next.run_last   = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      spi_valid <= 1'b0;
    end else begin
      if (adv) begin
        spi_valid <= busy;
      end
      if (stage_take) begin
        busy <= 1'b1;
      end else if (emit && last_byte) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      spi <= spi_next;
    end
    if (stage_take) begin
      word      <= stage.bits;
      frame_end <= stage.frame_end;
      pos       <= '0;
    end else if (emit) begin
      pos  <= pos + PosW'(1);
      // pixel bytes leave from the top of the word
      word <= {word[WordW-9:0], 8'h00};
    end
  end

endmodule

FILE: rtl/led_string_spi_frame_encoder.sv
// top level of the led string spi frame encoder
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   pix     | pix_valid, pix_ready | green, red, blue, frame_end
//   spi     | spi_valid, spi_ready | spi_byte, reset_fill, run_last
//
// each pixel gives 9 bytes, one per cycle while the output is not stalled by
// spi_ready. a frame-end pixel adds RESET_GAP_BYTES zero bytes after them.
// one pixel is staged behind the one being serialized, so input is taken
// while output stalls. after a transfer into an idle block, the first byte
// goes through the lane registers, the serializer word and the spi register.
// reset is synchronous and clears all valid flags.
module led_string_spi_frame_encoder #(
  parameter int unsigned RESET_GAP_BYTES = lsse_pkg::GapBytesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  lsse_pkg::pixel_t   pix,
  output logic               spi_valid,
  input  logic               spi_ready,
  output lsse_pkg::spi_out_t spi
);
  import lsse_pkg::*;

  stage_t           stage;
  logic             stage_valid;
  logic             stage_frame_end;
  logic [WordW-1:0] stage_bits;
  logic             stage_take;
  logic             pix_xfer;

  assign stage     = '{valid: stage_valid, frame_end: stage_frame_end, bits: stage_bits};
  assign pix_ready = !stage_valid || stage_take;
  assign pix_xfer  = pix_valid && pix_ready;

  lsse_lane u_lane_green (
    .clk   (clk),
    .load  (pix_xfer),
    .color (pix.green),
    .code  (stage_bits[WordW-1 -: LaneW])
  );

  lsse_lane u_lane_red (
    .clk   (clk),
    .load  (pix_xfer),
    .color (pix.red),
    .code  (stage_bits[WordW-1-LaneW -: LaneW])
  );

  lsse_lane u_lane_blue (
    .clk   (clk),
    .load  (pix_xfer),
    .color (pix.blue),
    .code  (stage_bits[LaneW-1:0])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (pix_xfer) begin
      stage_valid <= 1'b1;
    end else if (stage_take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      stage_frame_end <= pix.frame_end;
    end
  end

  lsse_merge #(
    .RESET_GAP_BYTES (RESET_GAP_BYTES)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .stage_take (stage_take),
    .spi_valid  (spi_valid),
    .spi_ready  (spi_ready),
    .spi        (spi)
  );

  // gap bytes are always zero
  assert property (@(posedge clk) disable iff (rst)
    spi_valid && spi.reset_fill |-> spi.spi_byte == 8'h00)
    else $error("nonzero byte in reset gap");

  // a full stage is only overwritten when the serializer takes it
  assert property (@(posedge clk) disable iff (rst)
    pix_xfer && stage.valid |-> stage_take)
    else $error("staged pixel overwritten");

  // the serializer never takes an empty stage
  assert property (@(posedge clk) disable iff (rst)
    stage_take |-> stage.valid)
    else $error("stage taken while empty");

  // a transfer always leaves the stage full
  assert property (@(posedge clk) disable iff (rst)
    pix_xfer |=> stage.valid)
    else $error("stage empty after transfer");

endmodule
